### sv/utf8_code_point_decoder_core_assert.svh
// assertion macros used by the checker file
`ifndef UTF8_CODE_POINT_DECODER_CORE_ASSERT_SVH
`define UTF8_CODE_POINT_DECODER_CORE_ASSERT_SVH

// property checked on the rising clock edge, masked while reset is high
`define U8DEC_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("u8dec assertion failed");

// property checked on every rising clock edge, reset included
`define U8DEC_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("u8dec assertion failed");

`endif

### sv/u8dec_pkg.sv
package u8dec_pkg;

   localparam int ByteW    = 8;
   localparam int CharLenW = 3;
   localparam int CodeW    = 31;

   // sequence lengths, zero marks an invalid character
   localparam logic [CharLenW-1:0] LenBad = 3'd0;
   localparam logic [CharLenW-1:0] Len1   = 3'd1;
   localparam logic [CharLenW-1:0] Len2   = 3'd2;
   localparam logic [CharLenW-1:0] Len3   = 3'd3;
   localparam logic [CharLenW-1:0] Len4   = 3'd4;
   localparam logic [CharLenW-1:0] Len5   = 3'd5;
   localparam logic [CharLenW-1:0] Len6   = 3'd6;

   // lead byte range limits
   localparam logic [ByteW-1:0] LeadCont  = 8'h80;
   localparam logic [ByteW-1:0] Lead2     = 8'hC0;
   localparam logic [ByteW-1:0] Lead3     = 8'hE0;
   localparam logic [ByteW-1:0] Lead4     = 8'hF0;
   localparam logic [ByteW-1:0] Lead5     = 8'hF8;
   localparam logic [ByteW-1:0] Lead6     = 8'hFC;
   localparam logic [ByteW-1:0] LeadIlleg = 8'hFE;

   localparam logic [1:0] ContTag = 2'b10;

   typedef struct packed {
      logic [CharLenW-1:0] char_length;
      logic [CodeW-1:0]    char_value;
   } result_type;

   // length called for by the lead byte
   function automatic logic [CharLenW-1:0] lead_length(input logic [ByteW-1:0] lead);
      logic [CharLenW-1:0] len;
      priority if (lead < LeadCont) begin
         len = Len1;
      end else if (lead < Lead2) begin
         len = LenBad;
      end else if (lead < Lead3) begin
         len = Len2;
      end else if (lead < Lead4) begin
         len = Len3;
      end else if (lead < Lead5) begin
         len = Len4;
      end else if (lead < Lead6) begin
         len = Len5;
      end else if (lead < LeadIlleg) begin
         len = Len6;
      end else begin
         len = LenBad;
      end
      return len;
   endfunction

endpackage

### sv/utf8_code_point_decoder_core.sv
// utf8 code point decoder, legacy six byte form. each req beat carries the
// first six bytes of a buffer and how many of them are present; each rsp beat
// returns the decoded length (1 to 6, 0 for invalid) and the code point (0 when
// invalid). the lead byte sets the length; every following byte inside the
// sequence must be 10xxxxxx and the sequence must fit in req_avail_count,
// otherwise the character is invalid. no overlong or surrogate checks are
// made. rsp_valid rises once the req beat has passed through both registers:
// the bytes sit in the input register and the decode runs from there into
// the result register. one beat is taken every cycle while rsp_ready is high;
// a stalled rsp holds the result stage of the two stage pipe, and req_ready
// stays high while either stage has room.
module utf8_code_point_decoder_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [u8dec_pkg::ByteW-1:0]        req_byte0,
   input  logic [u8dec_pkg::ByteW-1:0]        req_byte1,
   input  logic [u8dec_pkg::ByteW-1:0]        req_byte2,
   input  logic [u8dec_pkg::ByteW-1:0]        req_byte3,
   input  logic [u8dec_pkg::ByteW-1:0]        req_byte4,
   input  logic [u8dec_pkg::ByteW-1:0]        req_byte5,
   input  logic [u8dec_pkg::CharLenW-1:0]     req_avail_count,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [u8dec_pkg::CharLenW-1:0]     rsp_char_length,
   output logic [u8dec_pkg::CodeW-1:0]        rsp_char_value
);
   import u8dec_pkg::*;

   // input register stage
   logic                  in_vld_ff;
   logic [ByteW-1:0]      b0_ff, b1_ff, b2_ff, b3_ff, b4_ff, b5_ff;
   logic [CharLenW-1:0]   avail_ff;

   // result register stage
   logic                  out_vld_ff;
   logic                  out_vld_in;
   result_type            res_ff;
   result_type            res_in;

   logic                  out_adv;
   logic                  in_adv;

   // decode signals
   logic [CharLenW-1:0]   len;
   logic [5:1]            cont_ok;
   logic                  seq_ok;
   logic [CodeW-1:0]      cp;

   // the result stage moves when empty or drained this cycle
   assign out_adv   = !out_vld_ff || rsp_ready;
   // the input stage takes a beat when empty or moving on
   assign in_adv    = !in_vld_ff || out_adv;
   assign req_ready = in_adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (in_adv) begin
         in_vld_ff <= req_valid;
      end
   end

   // payload needs no reset
   always_ff @(posedge clock) begin
      if (in_adv && req_valid) begin
         b0_ff    <= req_byte0;
         b1_ff    <= req_byte1;
         b2_ff    <= req_byte2;
         b3_ff    <= req_byte3;
         b4_ff    <= req_byte4;
         b5_ff    <= req_byte5;
         avail_ff <= req_avail_count;
      end
   end

   // continuation bytes must carry the 10 tag
   assign cont_ok[1] = (b1_ff[7:6] == ContTag);
   assign cont_ok[2] = (b2_ff[7:6] == ContTag);
   assign cont_ok[3] = (b3_ff[7:6] == ContTag);
   assign cont_ok[4] = (b4_ff[7:6] == ContTag);
   assign cont_ok[5] = (b5_ff[7:6] == ContTag);

   assign len = lead_length(b0_ff);

   // assemble the payload bits, lead byte first
   always_comb begin
      seq_ok = 1'b0;
      cp     = '0;
      unique case (len)
         Len1: begin
            seq_ok = 1'b1;
            cp     = {24'd0, b0_ff[6:0]};
         end
         Len2: begin
            seq_ok = cont_ok[1];
            cp     = {20'd0, b0_ff[4:0], b1_ff[5:0]};
         end
         Len3: begin
            seq_ok = &cont_ok[2:1];
            cp     = {15'd0, b0_ff[3:0], b1_ff[5:0], b2_ff[5:0]};
         end
         Len4: begin
            seq_ok = &cont_ok[3:1];
            cp     = {10'd0, b0_ff[2:0], b1_ff[5:0], b2_ff[5:0], b3_ff[5:0]};
         end
         Len5: begin
            seq_ok = &cont_ok[4:1];
            cp     = {5'd0, b0_ff[1:0], b1_ff[5:0], b2_ff[5:0], b3_ff[5:0],
                      b4_ff[5:0]};
         end
         Len6: begin
            seq_ok = &cont_ok[5:1];
            cp     = {b0_ff[0], b1_ff[5:0], b2_ff[5:0], b3_ff[5:0], b4_ff[5:0],
                      b5_ff[5:0]};
         end
         default: begin
            // invalid lead byte
            seq_ok = 1'b0;
            cp     = '0;
         end
      endcase
   end

   // a short buffer or a bad tag voids the character
   always_comb begin
      if (seq_ok && (avail_ff >= len)) begin
         res_in.char_length = len;
         res_in.char_value  = cp;
      end else begin
         res_in.char_length = LenBad;
         res_in.char_value  = '0;
      end
   end

   assign out_vld_in = out_adv ? in_vld_ff : out_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_adv && in_vld_ff) begin
         res_ff <= res_in;
      end
   end

   assign rsp_valid       = out_vld_ff;
   assign rsp_char_length = res_ff.char_length;
   assign rsp_char_value  = res_ff.char_value;

endmodule

### sv/u8dec_checker.sv
`include "utf8_code_point_decoder_core_assert.svh"

module u8dec_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [u8dec_pkg::CharLenW-1:0]  rsp_char_length,
   input logic [u8dec_pkg::CodeW-1:0]     rsp_char_value
);
   import u8dec_pkg::*;

   // nothing comes out right after reset
   `U8DEC_ASSERT_ALWAYS(a_idle_after_reset, clock, reset |=> !rsp_valid)

   // an invalid character carries no code point
   `U8DEC_ASSERT(a_bad_is_zero, clock, reset, (rsp_valid && (rsp_char_length == LenBad)) |-> (rsp_char_value == '0))

   // the length never exceeds six
   `U8DEC_ASSERT(a_len_range, clock, reset, rsp_valid |-> (rsp_char_length <= Len6))

   // a one byte character stays within seven bits
   `U8DEC_ASSERT(a_ascii_width, clock, reset, (rsp_valid && (rsp_char_length == Len1)) |-> (rsp_char_value[CodeW-1:7] == '0))

   // a stalled rsp beat holds its payload
   `U8DEC_ASSERT(a_rsp_hold, clock, reset, (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_char_value) && $stable(rsp_char_length)))

endmodule

bind utf8_code_point_decoder_core u8dec_checker u_u8dec_checker (.*);
